[rtl/motion_playback_segment_planner_core_macros.svh]
// Assertion macros for the motion playback segment planner.
// Used by the port checker; needs nothing else.
`ifndef MOTION_PLAYBACK_SEGMENT_PLANNER_CORE_MACROS_SVH
`define MOTION_PLAYBACK_SEGMENT_PLANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpsp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpsp: next-cycle check failed");

`endif

[rtl/mpsp_pkg.sv]
// Shared types and constants of the motion playback segment planner.
// No dependencies; used by every module of the block.
package mpsp_pkg;

   localparam int POS_W      = 12;
   localparam int GRP_W      = 10;
   localparam int STAMP_W    = 24;
   localparam int TIME_W     = 28;
   localparam int SPEED_W    = 16;
   localparam int GTIME_W    = 16;
   localparam int RATE_W     = 7;
   localparam int PERIOD_W   = 10;
   localparam int THR_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_W      = TIME_W + 1;
   localparam int DIV_CNT_W  = 5;
   localparam int SCALED_W   = 22;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYBACK_RATE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SPEED   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_THRESHOLD = 3'd5;

   localparam logic [RATE_W-1:0]   RST_PLAYBACK_RATE   = 7'd10;
   localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD   = 10'd50;
   localparam logic [SPEED_W-1:0]  RST_MIN_SPEED       = 16'd100;
   localparam logic [SPEED_W-1:0]  RST_MAX_SPEED       = 16'd4000;
   localparam logic [SPEED_W-1:0]  RST_DEFAULT_SPEED   = 16'd1000;
   localparam logic [THR_W-1:0]    RST_SPLIT_THRESHOLD = 12'd500;

   localparam logic [GTIME_W-1:0]  PREP_GROUP_TIME = 16'd800;
   localparam logic [TIME_W-1:0]   PREP_WAIT       = 28'd900;
   localparam logic [SCALED_W-1:0] SPEED_SCALE     = 22'd1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_GAP,
      ST_TIME,
      ST_TWAIT,
      ST_PLAN,
      ST_SEG,
      ST_SDIV,
      ST_SWAIT,
      ST_SOUT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic calc_gap;
      logic load_t_raw;
      logic start_tdiv;
      logic load_t_div;
      logic plan;
      logic setup_seg;
      logic seg_second;
      logic start_sdiv;
      logic write_prep;
      logic write_seg;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic first_frame;
      logic rate_zero;
      logic split;
      logic seg_zero;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

[rtl/mpsp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on mpsp_pkg for widths.
module mpsp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mpsp_pkg::DIV_W-1:0]   dividend,
   input  logic [mpsp_pkg::TIME_W-1:0]  divisor,
   output logic                         done,
   output logic [mpsp_pkg::DIV_W-1:0]   quotient
);

   logic                            busy_ff;
   logic                            done_ff;
   logic [mpsp_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [mpsp_pkg::TIME_W-1:0]     rem_ff;
   logic [mpsp_pkg::TIME_W-1:0]     rem_in;
   logic [mpsp_pkg::DIV_W-1:0]      quo_ff;
   logic [mpsp_pkg::DIV_W-1:0]      quo_in;
   logic [mpsp_pkg::TIME_W-1:0]     divisor_ff;
   logic [mpsp_pkg::DIV_W-1:0]      trial;
   logic [mpsp_pkg::DIV_W-1:0]      diff;
   logic                            fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[mpsp_pkg::DIV_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? diff[mpsp_pkg::TIME_W-1:0] : trial[mpsp_pkg::TIME_W-1:0];
      quo_in = {quo_ff[mpsp_pkg::DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mpsp_pkg::DIV_CNT_W'(mpsp_pkg::DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == mpsp_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/mpsp_dpath.sv]
// Datapath: configuration registers, frame and history registers, segment
// arithmetic and the result register. Depends on mpsp_pkg and mpsp_div.
module mpsp_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  mpsp_pkg::cmd_type                 cmd,
   output mpsp_pkg::stat_type                stat,
   input  logic                              csr_write,
   input  logic [mpsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mpsp_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_first_frame,
   input  logic [mpsp_pkg::POS_W-1:0]        req_main_pos,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos0,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos1,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos2,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos3,
   input  logic [mpsp_pkg::STAMP_W-1:0]      req_stamp_ms,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [mpsp_pkg::POS_W-1:0]        rsp_main_target,
   output logic [mpsp_pkg::SPEED_W-1:0]      rsp_main_speed,
   output logic                              rsp_group_move,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out0,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out1,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out2,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out3,
   output logic [mpsp_pkg::GTIME_W-1:0]      rsp_group_time,
   output logic [mpsp_pkg::TIME_W-1:0]       rsp_wait_ms,
   output logic                              rsp_last_of_run
);

   // configuration
   logic [mpsp_pkg::RATE_W-1:0]    rate_ff;
   logic [mpsp_pkg::PERIOD_W-1:0]  period_ff;
   logic [mpsp_pkg::SPEED_W-1:0]   min_speed_ff;
   logic [mpsp_pkg::SPEED_W-1:0]   max_speed_ff;
   logic [mpsp_pkg::SPEED_W-1:0]   def_speed_ff;
   logic [mpsp_pkg::THR_W-1:0]     thr_ff;

   // frame and history
   logic [mpsp_pkg::POS_W-1:0]     cur_ff;
   logic [mpsp_pkg::GRP_W-1:0]     grp0_ff, grp1_ff, grp2_ff, grp3_ff;
   logic [mpsp_pkg::STAMP_W-1:0]   stamp_ff;
   logic [mpsp_pkg::POS_W-1:0]     prev_pos_ff;
   logic [mpsp_pkg::STAMP_W-1:0]   prev_stamp_ff;

   // planning
   logic [mpsp_pkg::STAMP_W-1:0]   gap_ff, gap_in;
   logic [mpsp_pkg::POS_W-1:0]     dist_ff, dist_in;
   logic [mpsp_pkg::POS_W-1:0]     mid_ff, mid_in;
   logic [mpsp_pkg::TIME_W-1:0]    t_ff;
   logic                           split_ff;
   logic [mpsp_pkg::POS_W-1:0]     seg_dist_ff, seg_dist_in;
   logic [mpsp_pkg::SCALED_W-1:0]  seg_k_ff;
   logic [mpsp_pkg::TIME_W-1:0]    seg_time_ff, seg_time_in;
   logic [mpsp_pkg::POS_W-1:0]     seg_from, seg_to;
   logic [mpsp_pkg::POS_W:0]       pos_sum;
   logic [mpsp_pkg::TIME_W-1:0]    half, rest, gap_x10, t_div, t_raw;

   // divider
   logic                           div_start;
   logic [mpsp_pkg::DIV_W-1:0]     div_dividend;
   logic [mpsp_pkg::TIME_W-1:0]    div_divisor;
   logic                           div_done;
   logic [mpsp_pkg::DIV_W-1:0]     div_quo;
   logic [mpsp_pkg::SPEED_W-1:0]   seg_speed;

   // result register
   logic                           rsp_valid_ff;
   logic [mpsp_pkg::POS_W-1:0]     tgt_ff;
   logic [mpsp_pkg::SPEED_W-1:0]   speed_ff;
   logic                           gm_ff;
   logic [mpsp_pkg::GRP_W-1:0]     out0_ff, out1_ff, out2_ff, out3_ff;
   logic [mpsp_pkg::GTIME_W-1:0]   gtime_ff;
   logic [mpsp_pkg::TIME_W-1:0]    wait_ff;
   logic                           last_ff;
   logic                           seg_gm;
   logic                           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= mpsp_pkg::RST_PLAYBACK_RATE;
         period_ff    <= mpsp_pkg::RST_SAMPLE_PERIOD;
         min_speed_ff <= mpsp_pkg::RST_MIN_SPEED;
         max_speed_ff <= mpsp_pkg::RST_MAX_SPEED;
         def_speed_ff <= mpsp_pkg::RST_DEFAULT_SPEED;
         thr_ff       <= mpsp_pkg::RST_SPLIT_THRESHOLD;
      end else if (csr_write) begin
         case (csr_index)
            mpsp_pkg::CSR_PLAYBACK_RATE:   rate_ff      <= csr_data[mpsp_pkg::RATE_W-1:0];
            mpsp_pkg::CSR_SAMPLE_PERIOD:   period_ff    <= csr_data[mpsp_pkg::PERIOD_W-1:0];
            mpsp_pkg::CSR_MIN_SPEED:       min_speed_ff <= csr_data;
            mpsp_pkg::CSR_MAX_SPEED:       max_speed_ff <= csr_data;
            mpsp_pkg::CSR_DEFAULT_SPEED:   def_speed_ff <= csr_data;
            mpsp_pkg::CSR_SPLIT_THRESHOLD: thr_ff       <= csr_data[mpsp_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Previous frame history: cleared by reset, advanced when a frame retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff   <= '0;
         prev_stamp_ff <= '0;
      end else if (cmd.commit) begin
         prev_pos_ff   <= cur_ff;
         prev_stamp_ff <= stamp_ff;
      end
   end

   always_comb begin
      gap_in  = (stamp_ff > prev_stamp_ff) ? (stamp_ff - prev_stamp_ff)
                                           : mpsp_pkg::STAMP_W'(period_ff);
      dist_in = (cur_ff > prev_pos_ff) ? (cur_ff - prev_pos_ff) : (prev_pos_ff - cur_ff);
      pos_sum = {1'b0, cur_ff} + {1'b0, prev_pos_ff};
      mid_in  = pos_sum[mpsp_pkg::POS_W:1];
      gap_x10 = (mpsp_pkg::TIME_W'(gap_ff) << 3) + (mpsp_pkg::TIME_W'(gap_ff) << 1);
      t_raw   = (gap_ff == '0) ? mpsp_pkg::TIME_W'(1) : mpsp_pkg::TIME_W'(gap_ff);
      t_div   = (div_quo[mpsp_pkg::TIME_W-1:0] == '0) ? mpsp_pkg::TIME_W'(1)
                                                     : div_quo[mpsp_pkg::TIME_W-1:0];
      half    = t_ff >> 1;
      rest    = t_ff - half;

      // Pick the end points and duration of the segment in hand.
      if (!split_ff) begin
         seg_from    = prev_pos_ff;
         seg_to      = cur_ff;
         seg_time_in = t_ff;
      end else if (!cmd.seg_second) begin
         seg_from    = prev_pos_ff;
         seg_to      = mid_ff;
         seg_time_in = half;
      end else begin
         seg_from    = mid_ff;
         seg_to      = cur_ff;
         seg_time_in = rest;
      end
      seg_dist_in = (seg_to > seg_from) ? (seg_to - seg_from) : (seg_from - seg_to);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_ff   <= req_main_pos;
         grp0_ff  <= req_group_pos0;
         grp1_ff  <= req_group_pos1;
         grp2_ff  <= req_group_pos2;
         grp3_ff  <= req_group_pos3;
         stamp_ff <= req_stamp_ms;
      end
      if (cmd.calc_gap) begin
         gap_ff  <= gap_in;
         dist_ff <= dist_in;
         mid_ff  <= mid_in;
      end
      if (cmd.load_t_raw) begin
         t_ff <= t_raw;
      end else if (cmd.load_t_div) begin
         t_ff <= t_div;
      end
      if (cmd.plan) begin
         split_ff <= (dist_ff > thr_ff) && (t_ff > mpsp_pkg::TIME_W'(1));
      end
      if (cmd.setup_seg) begin
         seg_dist_ff <= seg_dist_in;
         seg_k_ff    <= mpsp_pkg::SCALED_W'(seg_dist_in) * mpsp_pkg::SPEED_SCALE;
         seg_time_ff <= seg_time_in;
      end
   end

   always_comb begin
      div_start = cmd.start_tdiv || cmd.start_sdiv;
      if (cmd.start_tdiv) begin
         div_dividend = mpsp_pkg::DIV_W'(gap_x10);
         div_divisor  = mpsp_pkg::TIME_W'(rate_ff);
      end else begin
         // ceiling division: add divisor less one
         div_dividend = mpsp_pkg::DIV_W'(seg_k_ff) + mpsp_pkg::DIV_W'(seg_time_ff)
                        - mpsp_pkg::DIV_W'(1);
         div_divisor  = seg_time_ff;
      end
   end

   mpsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (seg_dist_ff == '0) begin
         seg_speed = def_speed_ff;
      end else if (div_quo < mpsp_pkg::DIV_W'(min_speed_ff)) begin
         seg_speed = min_speed_ff;
      end else if (div_quo > mpsp_pkg::DIV_W'(max_speed_ff)) begin
         seg_speed = max_speed_ff;
      end else begin
         seg_speed = div_quo[mpsp_pkg::SPEED_W-1:0];
      end
      seg_gm   = !(split_ff && cmd.seg_second);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_prep || cmd.write_seg) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_prep) begin
         tgt_ff   <= cur_ff;
         speed_ff <= def_speed_ff;
         gm_ff    <= 1'b1;
         out0_ff  <= grp0_ff;
         out1_ff  <= grp1_ff;
         out2_ff  <= grp2_ff;
         out3_ff  <= grp3_ff;
         gtime_ff <= mpsp_pkg::PREP_GROUP_TIME;
         wait_ff  <= mpsp_pkg::PREP_WAIT;
         last_ff  <= 1'b1;
      end else if (cmd.write_seg) begin
         tgt_ff   <= (split_ff && !cmd.seg_second) ? mid_ff : cur_ff;
         speed_ff <= seg_speed;
         gm_ff    <= seg_gm;
         out0_ff  <= seg_gm ? grp0_ff : '0;
         out1_ff  <= seg_gm ? grp1_ff : '0;
         out2_ff  <= seg_gm ? grp2_ff : '0;
         out3_ff  <= seg_gm ? grp3_ff : '0;
         gtime_ff <= seg_gm ? t_ff[mpsp_pkg::GTIME_W-1:0] : '0;
         wait_ff  <= !split_ff ? t_ff : (cmd.seg_second ? rest : half);
         last_ff  <= !split_ff || cmd.seg_second;
      end
   end

   assign stat.first_frame = req_first_frame;
   assign stat.rate_zero   = (rate_ff == '0);
   assign stat.split       = split_ff;
   assign stat.seg_zero    = (seg_dist_ff == '0);
   assign stat.div_done    = div_done;
   assign stat.out_free    = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_main_target = tgt_ff;
   assign rsp_main_speed  = speed_ff;
   assign rsp_group_move  = gm_ff;
   assign rsp_group_out0  = out0_ff;
   assign rsp_group_out1  = out1_ff;
   assign rsp_group_out2  = out2_ff;
   assign rsp_group_out3  = out3_ff;
   assign rsp_group_time  = gtime_ff;
   assign rsp_wait_ms     = wait_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[rtl/mpsp_ctrl.sv]
// Controller: sequences one frame through timing, division and result writes.
// Depends on mpsp_pkg for the state, command and status types.
module mpsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mpsp_pkg::stat_type  stat,
   output mpsp_pkg::cmd_type   cmd
);

   mpsp_pkg::state_type state_ff, state_in;
   logic                second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mpsp_pkg::ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      second_in      = second_ff;
      cmd            = '0;
      cmd.seg_second = second_ff;
      req_ready      = 1'b0;
      case (state_ff)
         mpsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = stat.first_frame ? mpsp_pkg::ST_PREP : mpsp_pkg::ST_GAP;
            end
         end
         mpsp_pkg::ST_PREP: begin
            if (stat.out_free) begin
               cmd.write_prep = 1'b1;
               cmd.commit     = 1'b1;
               state_in       = mpsp_pkg::ST_IDLE;
            end
         end
         mpsp_pkg::ST_GAP: begin
            cmd.calc_gap = 1'b1;
            state_in     = mpsp_pkg::ST_TIME;
         end
         mpsp_pkg::ST_TIME: begin
            if (stat.rate_zero) begin
               cmd.load_t_raw = 1'b1;
               state_in       = mpsp_pkg::ST_PLAN;
            end else begin
               cmd.start_tdiv = 1'b1;
               state_in       = mpsp_pkg::ST_TWAIT;
            end
         end
         mpsp_pkg::ST_TWAIT: begin
            if (stat.div_done) begin
               cmd.load_t_div = 1'b1;
               state_in       = mpsp_pkg::ST_PLAN;
            end
         end
         mpsp_pkg::ST_PLAN: begin
            cmd.plan  = 1'b1;
            second_in = 1'b0;
            state_in  = mpsp_pkg::ST_SEG;
         end
         mpsp_pkg::ST_SEG: begin
            cmd.setup_seg = 1'b1;
            state_in      = mpsp_pkg::ST_SDIV;
         end
         mpsp_pkg::ST_SDIV: begin
            // zero distance takes the default speed, no division
            if (stat.seg_zero) begin
               state_in = mpsp_pkg::ST_SOUT;
            end else begin
               cmd.start_sdiv = 1'b1;
               state_in       = mpsp_pkg::ST_SWAIT;
            end
         end
         mpsp_pkg::ST_SWAIT: begin
            if (stat.div_done) begin
               state_in = mpsp_pkg::ST_SOUT;
            end
         end
         mpsp_pkg::ST_SOUT: begin
            if (stat.out_free) begin
               cmd.write_seg = 1'b1;
               if (stat.split && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = mpsp_pkg::ST_SEG;
               end else begin
                  cmd.commit = 1'b1;
                  state_in   = mpsp_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mpsp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/motion_playback_segment_planner_core.sv]
// Channel  Direction  Handshake            Carries
// req      in         req_valid/req_ready  one recorded frame
// rsp      out        rsp_valid/rsp_ready  one move command
// csr      in         csr_valid/csr_ready  register index and write data
//
// Per frame: a first frame goes from acceptance through the prepare state into
// the result register. A later frame passes the gap and time states, with the
// time scaling division (skipped at playback rate zero), and the plan state, then
// per move the segment setup and the speed division (skipped at zero distance)
// before its write; a split makes two moves. One 29-step divider serves both.
// Reset is synchronous: it clears the controller, the history and the result
// valid flag, and loads the configuration defaults. A full result register
// holds the controller in its write state; the next frame is taken while the
// last result of the previous one still waits.
module motion_playback_segment_planner_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_first_frame,
   input  logic [mpsp_pkg::POS_W-1:0]        req_main_pos,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos0,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos1,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos2,
   input  logic [mpsp_pkg::GRP_W-1:0]        req_group_pos3,
   input  logic [mpsp_pkg::STAMP_W-1:0]      req_stamp_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mpsp_pkg::POS_W-1:0]        rsp_main_target,
   output logic [mpsp_pkg::SPEED_W-1:0]      rsp_main_speed,
   output logic                              rsp_group_move,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out0,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out1,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out2,
   output logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out3,
   output logic [mpsp_pkg::GTIME_W-1:0]      rsp_group_time,
   output logic [mpsp_pkg::TIME_W-1:0]       rsp_wait_ms,
   output logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mpsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mpsp_pkg::CSR_DATA_W-1:0]   csr_data
);

   mpsp_pkg::cmd_type  cmd;
   mpsp_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   mpsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpsp_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_first_frame (req_first_frame),
      .req_main_pos    (req_main_pos),
      .req_group_pos0  (req_group_pos0),
      .req_group_pos1  (req_group_pos1),
      .req_group_pos2  (req_group_pos2),
      .req_group_pos3  (req_group_pos3),
      .req_stamp_ms    (req_stamp_ms),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_main_target (rsp_main_target),
      .rsp_main_speed  (rsp_main_speed),
      .rsp_group_move  (rsp_group_move),
      .rsp_group_out0  (rsp_group_out0),
      .rsp_group_out1  (rsp_group_out1),
      .rsp_group_out2  (rsp_group_out2),
      .rsp_group_out3  (rsp_group_out3),
      .rsp_group_time  (rsp_group_time),
      .rsp_wait_ms     (rsp_wait_ms),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[rtl/mpsp_checker.sv]
// Port-level checks of the segment planner, bound to the top level.
// Depends on mpsp_pkg and motion_playback_segment_planner_core_macros.svh.
`include "motion_playback_segment_planner_core_macros.svh"

module mpsp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_first_frame,
   input logic [mpsp_pkg::POS_W-1:0]        req_main_pos,
   input logic [mpsp_pkg::GRP_W-1:0]        req_group_pos0,
   input logic [mpsp_pkg::GRP_W-1:0]        req_group_pos1,
   input logic [mpsp_pkg::GRP_W-1:0]        req_group_pos2,
   input logic [mpsp_pkg::GRP_W-1:0]        req_group_pos3,
   input logic [mpsp_pkg::STAMP_W-1:0]      req_stamp_ms,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mpsp_pkg::POS_W-1:0]        rsp_main_target,
   input logic [mpsp_pkg::SPEED_W-1:0]      rsp_main_speed,
   input logic                              rsp_group_move,
   input logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out0,
   input logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out1,
   input logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out2,
   input logic [mpsp_pkg::GRP_W-1:0]        rsp_group_out3,
   input logic [mpsp_pkg::GTIME_W-1:0]      rsp_group_time,
   input logic [mpsp_pkg::TIME_W-1:0]       rsp_wait_ms,
   input logic                              rsp_last_of_run,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [mpsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [mpsp_pkg::CSR_DATA_W-1:0]   csr_data
);

   // a stalled result transaction keeps its move
   `MPSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_main_target) && $stable(rsp_main_speed) && $stable(rsp_wait_ms) && $stable(rsp_last_of_run))

   // the closing half of a split carries no group command
   `MPSP_ASSERT_SAME(a_no_group, clock, reset, rsp_valid && !rsp_group_move, rsp_group_time == '0 && rsp_group_out0 == '0 && rsp_group_out1 == '0 && rsp_group_out2 == '0 && rsp_group_out3 == '0)

   // the opening half of a split waits half the group time
   `MPSP_ASSERT_SAME(a_split_half, clock, reset, rsp_valid && !rsp_last_of_run, rsp_group_move && rsp_group_time[15:1] == rsp_wait_ms[14:0])

   // no new frame is taken while a split still owes its second move
   `MPSP_ASSERT_SAME(a_split_busy, clock, reset, rsp_valid && !rsp_last_of_run, !req_ready)

endmodule

bind motion_playback_segment_planner_core mpsp_checker u_mpsp_checker (.*);
